>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst_n, prop)

`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/pnt_pkg.sv
// ----------------------------------------------------------------------------
// pnt_pkg
// shared constants and types of the perlin noise texture generator
// ----------------------------------------------------------------------------
`default_nettype none

package pnt_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int FRAC_BITS   = 16;

  localparam int PIX_W       = 12;
  localparam int SCALE_W     = 16;
  localparam int ZOFF_W      = 24;
  localparam int ZOFF_FRAC   = 16;
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;

  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int REM_W       = DIM_W + 1;
  localparam int NUM_SHIFT   = FRAC_BITS - 8;
  localparam int NUM_W       = PIX_W + SCALE_W + NUM_SHIFT;
  localparam int COORD_W     = 8 + FRAC_BITS;

  localparam int TABLE_DEPTH = 256;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [7:0] ALPHA_BYTE = 8'hff;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_SCALE  = 2'd0,
    REG_Z_OFFSET     = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         idx;
    logic [7:0]         val;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } item_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DIM_W-1:0]   dim_x;
    logic [DIM_W-1:0]   dim_y;
  } front_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/pnt_front.sv
// ----------------------------------------------------------------------------
// pnt_front
// input stage: takes items, scales pixel coordinates by a pipelined divider
// ----------------------------------------------------------------------------
`default_nettype none

module pnt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pnt_pkg::front_cfg_t         cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [7:0]                  table_index_i,
  input  logic [7:0]                  table_value_i,
  input  logic [pnt_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [pnt_pkg::PIX_W-1:0]   pixel_y_i,
  input  logic                        fifo_full_i,
  output logic                        push_o,
  output pnt_pkg::item_t              item_o
);
  import pnt_pkg::*;

  localparam int PROD_W = PIX_W + SCALE_W;

  logic                en;
  logic [PROD_W-1:0]   prod_x;
  logic [PROD_W-1:0]   prod_y;

  logic                vld_q [NUM_W+1];
  op_e                 op_q  [NUM_W+1];
  logic [7:0]          idx_q [NUM_W+1];
  logic [7:0]          val_q [NUM_W+1];
  logic [REM_W-1:0]    rx_q  [NUM_W+1];
  logic [REM_W-1:0]    ry_q  [NUM_W+1];
  logic [NUM_W-1:0]    nx_q  [NUM_W+1];
  logic [NUM_W-1:0]    ny_q  [NUM_W+1];
  logic [COORD_W-1:0]  qx_q  [NUM_W+1];
  logic [COORD_W-1:0]  qy_q  [NUM_W+1];

  assign en         = !fifo_full_i;
  assign in_stall_o = fifo_full_i;

  assign prod_x = PROD_W'(pixel_x_i) * PROD_W'(cfg_i.scale);
  assign prod_y = PROD_W'(pixel_y_i) * PROD_W'(cfg_i.scale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[0]  <= op_e'(op_i);
      idx_q[0] <= table_index_i;
      val_q[0] <= table_value_i;
      nx_q[0]  <= NUM_W'(prod_x) << NUM_SHIFT;
      ny_q[0]  <= NUM_W'(prod_y) << NUM_SHIFT;
      rx_q[0]  <= '0;
      ry_q[0]  <= '0;
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 1; k <= NUM_W; k++) begin : g_div
    logic [REM_W-1:0] rx_sh;
    logic [REM_W-1:0] ry_sh;
    logic             qx_bit;
    logic             qy_bit;

    assign rx_sh  = {rx_q[k-1][REM_W-2:0], nx_q[k-1][NUM_W-1]};
    assign ry_sh  = {ry_q[k-1][REM_W-2:0], ny_q[k-1][NUM_W-1]};
    assign qx_bit = (rx_sh >= {1'b0, cfg_i.dim_x});
    assign qy_bit = (ry_sh >= {1'b0, cfg_i.dim_y});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        op_q[k]  <= op_q[k-1];
        idx_q[k] <= idx_q[k-1];
        val_q[k] <= val_q[k-1];
        rx_q[k]  <= qx_bit ? rx_sh - {1'b0, cfg_i.dim_x} : rx_sh;
        ry_q[k]  <= qy_bit ? ry_sh - {1'b0, cfg_i.dim_y} : ry_sh;
        nx_q[k]  <= nx_q[k-1] << 1;
        ny_q[k]  <= ny_q[k-1] << 1;
        qx_q[k]  <= {qx_q[k-1][COORD_W-2:0], qx_bit};
        qy_q[k]  <= {qy_q[k-1][COORD_W-2:0], qy_bit};
      end
    end
  end

  assign push_o     = en && vld_q[NUM_W];
  assign item_o.op  = op_q[NUM_W];
  assign item_o.idx = idx_q[NUM_W];
  assign item_o.val = val_q[NUM_W];
  assign item_o.cx  = qx_q[NUM_W];
  assign item_o.cy  = qy_q[NUM_W];

endmodule

`default_nettype wire

>>> rtl/core/pnt_fifo.sv
// ----------------------------------------------------------------------------
// pnt_fifo
// short queue between the coordinate front end and the noise back end
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pnt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pnt_pkg::item_t  data_i,
  input  logic            pop_i,
  output pnt_pkg::item_t  data_o,
  output logic            valid_o,
  output logic            full_o
);
  import pnt_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q;
  logic [FIFO_AW-1:0] rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic [FIFO_AW:0]   count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));

  `ASSERT_PROP(a_push_not_full, clk_i, rst_ni, push_i |-> !full_o)
  `ASSERT_PROP(a_pop_not_empty, clk_i, rst_ni, pop_i |-> valid_o)
  `ASSERT_PROP(a_count_up, clk_i, rst_ni, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))

endmodule

`default_nettype wire

>>> rtl/core/pnt_back.sv
// ----------------------------------------------------------------------------
// pnt_back
// noise back end: table hashing, quintic fade, gradients, blend and gray map
// ----------------------------------------------------------------------------
`default_nettype none

module pnt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pnt_pkg::item_t                head_i,
  input  logic                          head_valid_i,
  output logic                          pop_o,
  input  logic [pnt_pkg::COORD_W-1:0]   z_coord_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    gray_o,
  output logic [31:0]                   pixel_word_o
);
  import pnt_pkg::*;

  localparam int FR     = FRAC_BITS;
  localparam int ONE    = 1 << FR;
  localparam int CO_W   = FR + 2;
  localparam int VAL_W  = FR + 3;
  localparam int FADE_W = FR + 1;
  localparam int Q_W    = FR + 4;
  localparam int NCOPY  = 7;

  function automatic logic signed [VAL_W-1:0] grad(input logic [7:0] hash,
                                                   input logic signed [CO_W-1:0] x,
                                                   input logic signed [CO_W-1:0] y,
                                                   input logic signed [CO_W-1:0] z);
    logic [3:0]              h;
    logic signed [VAL_W-1:0] gu;
    logic signed [VAL_W-1:0] gv;
    h  = hash[3:0];
    gu = (h < 4'd8) ? VAL_W'(x) : VAL_W'(y);
    if (h < 4'd4) begin
      gv = VAL_W'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      gv = VAL_W'(x);
    end else begin
      gv = VAL_W'(z);
    end
    if (h[0]) begin
      gu = -gu;
    end
    if (h[1]) begin
      gv = -gv;
    end
    return gu + gv;
  endfunction

  function automatic logic signed [VAL_W-1:0] lerp(input logic [FADE_W-1:0] t,
                                                   input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0]          d;
    logic signed [VAL_W+FADE_W+1:0] p;
    d = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
    p = $signed({1'b0, t}) * d;
    return a + VAL_W'(p >>> FR);
  endfunction

  logic en;

  // permutation table copies
  logic       mem_we [NCOPY];
  logic [7:0] mem_wa [NCOPY];
  logic [7:0] mem_wd [NCOPY];
  logic [7:0] ra0    [NCOPY];
  logic [7:0] ra1    [NCOPY];
  logic [7:0] rd0_q  [NCOPY];
  logic [7:0] rd1_q  [NCOPY];

  logic [7:0] x_int;
  logic [7:0] z_int;
  logic [7:0] a_h, b_h, aa_h, ab_h, ba_h, bb_h;

  // stage registers
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, out_valid_q;
  op_e  op1_q, op2_q, op3_q, op4_q, op5_q, op6_q, op7_q;
  logic [7:0] idx1_q, val1_q, idx2_q, val2_q;
  logic [7:0] y1_q;

  logic [FR-1:0]     frac0   [3];
  logic [FR-1:0]     frac1_q [3];
  logic [FR-1:0]     frac2_q [3];
  logic [FR-1:0]     frac3_q [3];
  logic [FR-1:0]     t2_d    [3];
  logic [FR-1:0]     t2_1_q  [3];
  logic [FR-1:0]     t3_d    [3];
  logic [Q_W-1:0]    q_d     [3];
  logic [FR-1:0]     t3_2_q  [3];
  logic [Q_W-1:0]    q_2_q   [3];
  logic [FADE_W-1:0] fade_d  [3];
  logic [FADE_W-1:0] fade3_q [3];
  logic [FADE_W-1:0] fade4_q [3];
  logic [FADE_W-1:0] fv5_q, fw5_q, fw6_q;

  logic signed [CO_W-1:0]  xs, ys, zs, x1s, y1s, z1s;
  logic signed [VAL_W-1:0] grad_d  [8];
  logic signed [VAL_W-1:0] grad4_q [8];
  logic signed [VAL_W-1:0] e_d     [4];
  logic signed [VAL_W-1:0] e5_q    [4];
  logic signed [VAL_W-1:0] l_d     [2];
  logic signed [VAL_W-1:0] l6_q    [2];
  logic signed [VAL_W-1:0] n_d;
  logic signed [VAL_W-1:0] n7_q;

  logic signed [VAL_W:0]   shifted;
  logic [VAL_W+8:0]        scaled;
  logic [VAL_W+8:0]        gray_wide;
  logic [7:0]              gray_d;
  logic [7:0]              gray_q;

  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && head_valid_i;

  assign x_int = head_i.cx[COORD_W-1:FR];
  assign z_int = z_coord_i[COORD_W-1:FR];

  assign frac0[0] = head_i.cx[FR-1:0];
  assign frac0[1] = head_i.cy[FR-1:0];
  assign frac0[2] = z_coord_i[FR-1:0];

  // hash chain
  assign a_h  = rd0_q[0] + y1_q;
  assign b_h  = rd1_q[0] + y1_q;
  assign aa_h = rd0_q[1] + z_int;
  assign ab_h = rd1_q[1] + z_int;
  assign ba_h = rd0_q[2] + z_int;
  assign bb_h = rd1_q[2] + z_int;

  always_comb begin
    ra0[0] = x_int;
    ra1[0] = x_int + 8'd1;
    ra0[1] = a_h;
    ra1[1] = a_h + 8'd1;
    ra0[2] = b_h;
    ra1[2] = b_h + 8'd1;
    ra0[3] = aa_h;
    ra1[3] = aa_h + 8'd1;
    ra0[4] = ba_h;
    ra1[4] = ba_h + 8'd1;
    ra0[5] = ab_h;
    ra1[5] = ab_h + 8'd1;
    ra0[6] = bb_h;
    ra1[6] = bb_h + 8'd1;
  end

  // a load writes each copy as it passes the stage that reads it
  always_comb begin
    for (int c = 0; c < NCOPY; c++) begin
      if (c == 0) begin
        mem_we[c] = en && head_valid_i && (head_i.op == OP_LOAD);
        mem_wa[c] = head_i.idx;
        mem_wd[c] = head_i.val;
      end else if (c < 3) begin
        mem_we[c] = en && v1_q && (op1_q == OP_LOAD);
        mem_wa[c] = idx1_q;
        mem_wd[c] = val1_q;
      end else begin
        mem_we[c] = en && v2_q && (op2_q == OP_LOAD);
        mem_wa[c] = idx2_q;
        mem_wd[c] = val2_q;
      end
    end
  end

  for (genvar c = 0; c < NCOPY; c++) begin : g_perm
    logic [7:0] perm_mem [TABLE_DEPTH];

    always_ff @(posedge clk_i) begin
      if (mem_we[c]) begin
        perm_mem[mem_wa[c]] <= mem_wd[c];
      end
      if (en) begin
        rd0_q[c] <= perm_mem[ra0[c]];
        rd1_q[c] <= perm_mem[ra1[c]];
      end
    end
  end

  // quintic fade, three multiplier stages
  always_comb begin
    logic [2*FR-1:0]   sq;
    logic [2*FR-1:0]   cu;
    logic [Q_W-1:0]    pos;
    logic [Q_W-1:0]    neg;
    logic [2*FR+3:0]   pf;
    logic [Q_W-1:0]    fw;
    for (int i = 0; i < 3; i++) begin
      sq        = (2*FR)'(frac0[i]) * (2*FR)'(frac0[i]);
      t2_d[i]   = sq[2*FR-1:FR];
      cu        = (2*FR)'(t2_1_q[i]) * (2*FR)'(frac1_q[i]);
      t3_d[i]   = cu[2*FR-1:FR];
      pos       = Q_W'(t2_1_q[i]) * Q_W'(6) + Q_W'(10 * ONE);
      neg       = Q_W'(frac1_q[i]) * Q_W'(15);
      q_d[i]    = (pos >= neg) ? pos - neg : '0;
      pf        = (2*FR+4)'(t3_2_q[i]) * (2*FR+4)'(q_2_q[i]);
      fw        = pf[2*FR+3:FR];
      fade_d[i] = (fw > Q_W'(ONE)) ? FADE_W'(ONE) : fw[FADE_W-1:0];
    end
  end

  // gradients
  assign xs  = $signed({2'b00, frac3_q[0]});
  assign ys  = $signed({2'b00, frac3_q[1]});
  assign zs  = $signed({2'b00, frac3_q[2]});
  assign x1s = xs - $signed(CO_W'(ONE));
  assign y1s = ys - $signed(CO_W'(ONE));
  assign z1s = zs - $signed(CO_W'(ONE));

  always_comb begin
    grad_d[0] = grad(rd0_q[3], xs,  ys,  zs);
    grad_d[1] = grad(rd0_q[4], x1s, ys,  zs);
    grad_d[2] = grad(rd0_q[5], xs,  y1s, zs);
    grad_d[3] = grad(rd0_q[6], x1s, y1s, zs);
    grad_d[4] = grad(rd1_q[3], xs,  ys,  z1s);
    grad_d[5] = grad(rd1_q[4], x1s, ys,  z1s);
    grad_d[6] = grad(rd1_q[5], xs,  y1s, z1s);
    grad_d[7] = grad(rd1_q[6], x1s, y1s, z1s);
  end

  // blend
  always_comb begin
    e_d[0] = lerp(fade4_q[0], grad4_q[0], grad4_q[1]);
    e_d[1] = lerp(fade4_q[0], grad4_q[2], grad4_q[3]);
    e_d[2] = lerp(fade4_q[0], grad4_q[4], grad4_q[5]);
    e_d[3] = lerp(fade4_q[0], grad4_q[6], grad4_q[7]);
    l_d[0] = lerp(fv5_q, e5_q[0], e5_q[1]);
    l_d[1] = lerp(fv5_q, e5_q[2], e5_q[3]);
    n_d    = lerp(fw6_q, l6_q[0], l6_q[1]);
  end

  // gray map
  always_comb begin
    shifted   = $signed({n7_q[VAL_W-1], n7_q}) + $signed((VAL_W+1)'(ONE));
    scaled    = (VAL_W+9)'(shifted[VAL_W-1:0]) * (VAL_W+9)'(255);
    gray_wide = scaled >> (FR + 1);
    if (shifted <= 0) begin
      gray_d = 8'd0;
    end else if (gray_wide > (VAL_W+9)'(255)) begin
      gray_d = 8'd255;
    end else begin
      gray_d = gray_wide[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= head_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      out_valid_q <= v7_q && (op7_q == OP_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q   <= head_i.op;
      idx1_q  <= head_i.idx;
      val1_q  <= head_i.val;
      y1_q    <= head_i.cy[COORD_W-1:FR];
      frac1_q <= frac0;
      t2_1_q  <= t2_d;

      op2_q   <= op1_q;
      idx2_q  <= idx1_q;
      val2_q  <= val1_q;
      frac2_q <= frac1_q;
      t3_2_q  <= t3_d;
      q_2_q   <= q_d;

      op3_q   <= op2_q;
      frac3_q <= frac2_q;
      fade3_q <= fade_d;

      op4_q   <= op3_q;
      grad4_q <= grad_d;
      fade4_q <= fade3_q;

      op5_q   <= op4_q;
      e5_q    <= e_d;
      fv5_q   <= fade4_q[1];
      fw5_q   <= fade4_q[2];

      op6_q   <= op5_q;
      l6_q    <= l_d;
      fw6_q   <= fw5_q;

      op7_q   <= op6_q;
      n7_q    <= n_d;

      gray_q  <= gray_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gray_o       = gray_q;
  assign pixel_word_o = {ALPHA_BYTE, gray_q, gray_q, gray_q};

endmodule

`default_nettype wire

>>> rtl/core/perlin_noise_texture_generator_unit.sv
// ----------------------------------------------------------------------------
// perlin_noise_texture_generator_unit
// order: coordinate divider pipe, then the queue, then the noise back end
// throughput: one item per cycle while the queue is not full and the output
//   is not stalled, set by the one-bit-per-stage divider pipe
// reset: registers return to their defaults, the pipes and the queue empty;
//   the permutation table is not cleared and must be loaded before use
// ----------------------------------------------------------------------------
`default_nettype none

module perlin_noise_texture_generator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pnt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pnt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [7:0]                      table_index_i,
  input  logic [7:0]                      table_value_i,
  input  logic [pnt_pkg::PIX_W-1:0]       pixel_x_i,
  input  logic [pnt_pkg::PIX_W-1:0]       pixel_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      gray_o,
  output logic [31:0]                     pixel_word_o
);
  import pnt_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
    logic [DIM_W+CFG_DIM_W-1:0] dw;
    dw = (DIM_W+CFG_DIM_W)'(d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (dw > (DIM_W+CFG_DIM_W)'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(d);
  endfunction

  logic [SCALE_W-1:0]          noise_scale_q;
  logic [ZOFF_W-1:0]           z_offset_q;
  logic [CFG_DIM_W-1:0]        image_width_q;
  logic [CFG_DIM_W-1:0]        image_height_q;

  front_cfg_t                  front_cfg;
  logic [ZOFF_W+FRAC_BITS-1:0] z_wide;
  logic [COORD_W-1:0]          z_coord;

  logic  fifo_full;
  logic  push;
  logic  pop;
  logic  head_valid;
  item_t push_item;
  item_t head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_scale_q  <= SCALE_W'(256);
      z_offset_q     <= ZOFF_W'(39322);
      image_width_q  <= CFG_DIM_W'(256);
      image_height_q <= CFG_DIM_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_NOISE_SCALE:  noise_scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_Z_OFFSET:     z_offset_q     <= cfg_data_i[ZOFF_W-1:0];
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign front_cfg.scale = noise_scale_q;
  assign front_cfg.dim_x = clamp_dim(image_width_q);
  assign front_cfg.dim_y = clamp_dim(image_height_q);

  assign z_wide  = {z_offset_q, FRAC_BITS'(0)};
  assign z_coord = z_wide[ZOFF_FRAC+COORD_W-1:ZOFF_FRAC];

  pnt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (front_cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  pnt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .pop_i   (pop),
    .data_o  (head_item),
    .valid_o (head_valid),
    .full_o  (fifo_full)
  );

  pnt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .z_coord_i    (z_coord),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .gray_o       (gray_o),
    .pixel_word_o (pixel_word_o)
  );

endmodule

`default_nettype wire
